>>> hdl/crc_header_deframer_with_heartbeat_assert.svh
// Assertion macros for the CRC header deframer checker.
// Used by chdf_checker; no other dependencies.
`ifndef CRC_HEADER_DEFRAMER_WITH_HEARTBEAT_ASSERT_SVH
`define CRC_HEADER_DEFRAMER_WITH_HEARTBEAT_ASSERT_SVH

// same-cycle implication
`define CHDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chdf assertion failed");

// next-cycle implication
`define CHDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chdf assertion failed");

`endif

>>> hdl/chdf_pkg.sv
// Shared types, constants and the CRC-32 byte update for the deframer.
// No dependencies.
package chdf_pkg;

  localparam int unsigned HeaderBytes    = 12;
  localparam int unsigned CrcBytes       = 8;
  localparam logic [7:0]  ResetCredit    = 8'd2;
  localparam logic [31:0] ResetMaxLength = 32'd65536;
  localparam logic [31:0] CrcPoly        = 32'hEDB88320;
  localparam logic [31:0] CrcInit        = 32'hFFFFFFFF;
  localparam logic [7:0]  CreditMax      = 8'hFF;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhClosed  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    KPayload = 3'd0,
    KCrcErr  = 3'd1,
    KBadLen  = 3'd2,
    KSendHb  = 3'd3,
    KTimeout = 3'd4,
    KHbRecv  = 3'd5
  } kind_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CfgInitialCredit = 1'b0,
    CfgMaxLength     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] frame_tag;
    logic [7:0]  payload_byte;
    logic        last;
    logic [7:0]  credit;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/chdf_in_if.sv
// Input channel: received byte or heartbeat tick, valid/ready handshake.
// Depends on nothing.
interface chdf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

>>> hdl/chdf_out_if.sv
// Result channel: deframer events, valid/ready handshake.
// Depends on chdf_pkg.
interface chdf_out_if;
  logic                valid;
  logic                ready;
  chdf_pkg::kind_e     kind;
  logic [31:0]         frame_tag;
  logic [7:0]          payload_byte;
  logic                last;
  logic [7:0]          credit;

  modport source (output valid, output kind, output frame_tag, output payload_byte,
                  output last, output credit, input ready);
  modport sink   (input valid, input kind, input frame_tag, input payload_byte,
                  input last, input credit, output ready);
endinterface

>>> hdl/crc_header_deframer_with_heartbeat.sv
// A result is registered and presented in the cycle after the transaction that causes it is accepted.
// Throughput: one transaction per cycle while the output register is empty or being taken;
// the CRC-32 byte update and the header checks are combinational, ahead of the single output register.
// Reset: link in header phase, credit 2, max length 65536, output register empty.
// Depends on chdf_pkg, chdf_in_if, chdf_out_if and chdf_core.
module crc_header_deframer_with_heartbeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  chdf_in_if.sink     in_i,
  chdf_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic              in_fire;
  logic              res_valid;
  chdf_pkg::result_t res;
  logic              out_vld_q, out_vld_d;
  chdf_pkg::result_t out_q;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  chdf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .command_i   (in_i.command),
    .data_byte_i (in_i.data_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (in_fire && res_valid) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.frame_tag    = out_q.frame_tag;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.last         = out_q.last;
  assign out_o.credit       = out_q.credit;

endmodule

>>> hdl/chdf_core.sv
// Deframer state: header assembly, CRC check, payload count, heartbeat credit.
// Depends on chdf_pkg; driven by the top level's handshake.
module chdf_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 command_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 res_valid_o,
  output chdf_pkg::result_t    res_o
);

  localparam logic [3:0] HdrLastIdx = 4'(chdf_pkg::HeaderBytes - 1);
  localparam logic [3:0] CrcIdx     = 4'(chdf_pkg::CrcBytes);

  chdf_pkg::phase_e phase_q, phase_d;
  logic [3:0]  header_index_q, header_index_d;
  logic [63:0] header_fields_q, header_fields_d;
  logic [31:0] running_crc_q, running_crc_d;
  logic [31:0] received_crc_q, received_crc_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [7:0]  credit_q, credit_d;
  logic [7:0]  init_credit_q, init_credit_d;
  logic [31:0] max_length_q, max_length_d;

  logic        is_tick, credit_nz, hdr_last, crc_ok, len_ok, pay_end, tag_zero;
  logic [31:0] hdr_tag, hdr_len, rx_crc_full, bl_dec;
  logic [3:0]  crc_off;

  assign is_tick     = (command_i == chdf_pkg::CmdTick);
  assign credit_nz   = (credit_q != 8'd0);
  assign hdr_last    = (header_index_q == HdrLastIdx);
  assign hdr_tag     = header_fields_q[31:0];
  assign hdr_len     = header_fields_q[63:32];
  assign tag_zero    = (hdr_tag == 32'd0);
  assign rx_crc_full = received_crc_q | {data_byte_i, 24'd0};
  assign crc_ok      = ((running_crc_q ^ chdf_pkg::CrcInit) == rx_crc_full);
  assign len_ok      = (hdr_len != 32'd0) && (hdr_len <= max_length_q);
  assign bl_dec      = (bytes_left_q != 32'd0) ? bytes_left_q - 32'd1 : 32'd0;
  assign pay_end     = (bl_dec == 32'd0);
  assign crc_off     = header_index_q - CrcIdx;

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        chdf_pkg::PhHeader: begin
          if (is_tick) begin
            if (!credit_nz) phase_d = chdf_pkg::PhClosed;
          end else if (hdr_last) begin
            phase_d = (crc_ok && len_ok) ? chdf_pkg::PhPayload : chdf_pkg::PhClosed;
          end
        end
        chdf_pkg::PhPayload: begin
          if (is_tick) begin
            if (!credit_nz) phase_d = chdf_pkg::PhClosed;
          end else if (pay_end) begin
            phase_d = chdf_pkg::PhHeader;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_comb begin
    header_index_d  = header_index_q;
    header_fields_d = header_fields_q;
    running_crc_d   = running_crc_q;
    received_crc_d  = received_crc_q;
    bytes_left_d    = bytes_left_q;
    credit_d        = credit_q;
    init_credit_d   = init_credit_q;
    max_length_d    = max_length_q;
    res_valid_o     = 1'b0;
    res_o.kind         = chdf_pkg::KPayload;
    res_o.frame_tag    = 32'd0;
    res_o.payload_byte = 8'd0;
    res_o.last         = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chdf_pkg::CfgInitialCredit: begin
          init_credit_d = cfg_data_i[7:0];
          credit_d      = cfg_data_i[7:0];
        end
        chdf_pkg::CfgMaxLength: max_length_d = cfg_data_i;
        default: ;
      endcase
    end

    if (accept_i) begin
      unique case (phase_q)
        chdf_pkg::PhHeader, chdf_pkg::PhPayload: begin
          if (is_tick) begin
            res_valid_o = 1'b1;
            if (credit_nz) begin
              credit_d   = credit_q - 8'd1;
              res_o.kind = chdf_pkg::KSendHb;
            end else begin
              res_o.kind = chdf_pkg::KTimeout;
            end
          end else if (phase_q == chdf_pkg::PhHeader) begin
            if (header_index_q < CrcIdx) begin
              header_fields_d[{header_index_q[2:0], 3'b000} +: 8] = data_byte_i;
              running_crc_d = chdf_pkg::crc32_byte(running_crc_q, data_byte_i);
            end else begin
              received_crc_d = received_crc_q
                             | ({24'd0, data_byte_i} << {crc_off[1:0], 3'b000});
            end
            if (!hdr_last) begin
              header_index_d = header_index_q + 4'd1;
            end else if (!crc_ok) begin
              res_valid_o = 1'b1;
              res_o.kind  = chdf_pkg::KCrcErr;
            end else if (!len_ok) begin
              res_valid_o     = 1'b1;
              res_o.kind      = chdf_pkg::KBadLen;
              res_o.frame_tag = hdr_tag;
            end else begin
              header_index_d = 4'd0;
              bytes_left_d   = hdr_len;
            end
          end else begin
            bytes_left_d = bl_dec;
            if (pay_end) begin
              header_index_d  = 4'd0;
              running_crc_d   = chdf_pkg::CrcInit;
              received_crc_d  = 32'd0;
              res_valid_o     = 1'b1;
              res_o.frame_tag = hdr_tag;
              if (tag_zero) begin
                if (credit_q != chdf_pkg::CreditMax) credit_d = credit_q + 8'd1;
                res_o.kind = chdf_pkg::KHbRecv;
              end else begin
                res_o.kind         = chdf_pkg::KPayload;
                res_o.payload_byte = data_byte_i;
                res_o.last         = 1'b1;
              end
            end else if (!tag_zero) begin
              res_valid_o        = 1'b1;
              res_o.kind         = chdf_pkg::KPayload;
              res_o.frame_tag    = hdr_tag;
              res_o.payload_byte = data_byte_i;
            end
          end
        end
        default: ;
      endcase
    end
    res_o.credit = credit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= chdf_pkg::PhHeader;
      header_index_q  <= 4'd0;
      header_fields_q <= 64'd0;
      running_crc_q   <= chdf_pkg::CrcInit;
      received_crc_q  <= 32'd0;
      bytes_left_q    <= 32'd0;
      credit_q        <= chdf_pkg::ResetCredit;
      init_credit_q   <= chdf_pkg::ResetCredit;
      max_length_q    <= chdf_pkg::ResetMaxLength;
    end else begin
      phase_q         <= phase_d;
      header_index_q  <= header_index_d;
      header_fields_q <= header_fields_d;
      running_crc_q   <= running_crc_d;
      received_crc_q  <= received_crc_d;
      bytes_left_q    <= bytes_left_d;
      credit_q        <= credit_d;
      init_credit_q   <= init_credit_d;
      max_length_q    <= max_length_d;
    end
  end

endmodule

>>> hdl/chdf_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// Depends on chdf_pkg and crc_header_deframer_with_heartbeat_assert.svh.
`include "crc_header_deframer_with_heartbeat_assert.svh"

module chdf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input chdf_pkg::kind_e kind_i,
  input logic [31:0]     frame_tag_i,
  input logic [7:0]      payload_byte_i,
  input logic            last_i,
  input logic [7:0]      credit_i
);

  logic        closing_fire;
  logic        out_stall;
  logic [51:0] out_bundle;
  logic        out_timeout;
  logic        timeout_clean;

  assign closing_fire = out_valid_i && out_ready_i && (kind_i == chdf_pkg::KCrcErr
                        || kind_i == chdf_pkg::KBadLen || kind_i == chdf_pkg::KTimeout);
  assign out_stall     = out_valid_i && !out_ready_i;
  assign out_bundle    = {kind_i, frame_tag_i, payload_byte_i, last_i, credit_i};
  assign out_timeout   = out_valid_i && (kind_i == chdf_pkg::KTimeout);
  assign timeout_clean = (credit_i == 8'd0) && (frame_tag_i == 32'd0);

  `CHDF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_bundle))
  `CHDF_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)
  `CHDF_ASSERT_NXT(a_closed_silent, clk_i, rst_ni, closing_fire && !in_valid_i, !out_valid_i)
  `CHDF_ASSERT_IMP(a_timeout_zero, clk_i, rst_ni, out_timeout, timeout_clean)

endmodule

bind crc_header_deframer_with_heartbeat chdf_checker u_chdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .frame_tag_i    (out_o.frame_tag),
  .payload_byte_i (out_o.payload_byte),
  .last_i         (out_o.last),
  .credit_i       (out_o.credit)
);
